// ===== rtl/obc_pkg.sv =====
// shared constants and the arctangent table for the oriented box containment unit
package obc_pkg;

  // inverse cordic gain, unsigned q16, held with a zero sign bit
  localparam int GAIN_BITS = 16;
  localparam logic signed [GAIN_BITS:0] INV_GAIN = (GAIN_BITS + 1)'(39797);

  // fraction bits added to the working values by the gain multiply
  localparam int GUARD_SHIFT = 16;

  // angle accumulator: 2^TURN_BITS is one full turn, with headroom for the sum of the table
  localparam int TURN_BITS  = 32;
  localparam int ZACC_BITS  = 34;
  localparam int ATAN_COUNT = 24;
  localparam int ATAN_IDX_BITS = 5;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TURN_BITS-1:0] atan_turn(input logic [ATAN_IDX_BITS-1:0] idx);
    logic [TURN_BITS-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/obc_cordic.sv =====
// pipelined cordic rotator, one micro-rotation per register stage
module obc_cordic import obc_pkg::*; #(
  parameter int WORK_BITS = 43,
  parameter int STEPS     = 16,
  parameter int TAG_BITS  = 45
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORK_BITS-1:0] x_i,
  input  logic signed [WORK_BITS-1:0] y_i,
  input  logic signed [ZACC_BITS-1:0] z_i,
  input  logic        [TAG_BITS-1:0]  tag_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORK_BITS-1:0] x_o,
  output logic signed [WORK_BITS-1:0] y_o,
  output logic        [TAG_BITS-1:0]  tag_o
);

  localparam logic signed [ZACC_BITS-1:0] RES_LIM =
    ZACC_BITS'(2 * atan_turn(ATAN_IDX_BITS'(STEPS - 1)));

  logic                        valid_q [1:STEPS];
  logic                        adv     [1:STEPS];
  logic signed [WORK_BITS-1:0] x_q     [1:STEPS];
  logic signed [WORK_BITS-1:0] y_q     [1:STEPS];
  logic signed [ZACC_BITS-1:0] z_q     [1:STEPS];
  logic        [TAG_BITS-1:0]  tag_q   [1:STEPS];

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic                        prv_valid;
    logic signed [WORK_BITS-1:0] prv_x, prv_y, x_sh, y_sh, x_d, y_d;
    logic signed [ZACC_BITS-1:0] prv_z, ang, z_d;
    logic        [TAG_BITS-1:0]  prv_tag;

    if (k == 1) begin : g_src_in
      assign prv_valid = in_valid_i;
      assign prv_x     = x_i;
      assign prv_y     = y_i;
      assign prv_z     = z_i;
      assign prv_tag   = tag_i;
    end else begin : g_src_stage
      assign prv_valid = valid_q[k-1];
      assign prv_x     = x_q[k-1];
      assign prv_y     = y_q[k-1];
      assign prv_z     = z_q[k-1];
      assign prv_tag   = tag_q[k-1];
    end

    // a stage takes new data when empty or when its content moves on
    if (k == STEPS) begin : g_adv_last
      assign adv[k] = !valid_q[k] || !out_stall_i;
    end else begin : g_adv_mid
      assign adv[k] = !valid_q[k] || adv[k+1];
    end

    assign ang  = $signed({{(ZACC_BITS-TURN_BITS){1'b0}}, atan_turn(ATAN_IDX_BITS'(k - 1))});
    // arithmetic shift floors toward minus infinity
    assign x_sh = prv_x >>> (k - 1);
    assign y_sh = prv_y >>> (k - 1);

    always_comb begin
      if (!prv_z[ZACC_BITS-1]) begin
        x_d = prv_x - y_sh;
        y_d = prv_y + x_sh;
        z_d = prv_z - ang;
      end else begin
        x_d = prv_x + y_sh;
        y_d = prv_y - x_sh;
        z_d = prv_z + ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (adv[k]) begin
        valid_q[k] <= prv_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && prv_valid) begin
        x_q[k]   <= x_d;
        y_q[k]   <= y_d;
        z_q[k]   <= z_d;
        tag_q[k] <= prv_tag;
      end
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = valid_q[STEPS];
  assign x_o         = x_q[STEPS];
  assign y_o         = y_q[STEPS];
  assign tag_o       = tag_q[STEPS];

  // residual angle has converged once all micro-rotations are done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STEPS] |-> (z_q[STEPS] <= RES_LIM && z_q[STEPS] >= -RES_LIM))
    else $error("cordic residual angle out of bound");

  // a stall can only come from a full chain backed up by the consumer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_q[1] && out_valid_o && out_stall_i))
    else $error("cordic stalls without a full backed-up chain");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(x_o) && $stable(y_o) && $stable(tag_o)))
    else $error("cordic result changed while stalled");

endmodule

// ===== rtl/oriented_box_containment_unit.sv =====
// top level: point in oriented bounding box test with a pipelined cordic rotation
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | point_*, center_*, heading, half_*
//  out     | source    | out_valid_o / out_stall_i | inside_res
//
//  one transaction per cycle in steady state while out_stall_i is low; the registers in order are
//  offset stage, quadrant turn and gain multiply, one stage per cordic step, compare
//  the rate is set by the fully pipelined cordic chain, one micro-rotation per stage
//  reset clears only the valid bits; data registers load on transfer and need no reset
//  an output stall fills empty stages first, so in_stall_o rises only when every stage is full
module oriented_box_containment_unit import obc_pkg::*; #(
  parameter int COORD_BITS   = 24,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  logic        [ANGLE_BITS-1:0] heading_i,
  input  logic        [COORD_BITS-2:0] half_x_i,
  input  logic        [COORD_BITS-2:0] half_y_i,
  input  logic        [COORD_BITS-2:0] half_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o
);

  localparam int HALF_BITS   = COORD_BITS - 1;
  // exact coordinate difference
  localparam int DIFF_BITS   = COORD_BITS + 1;
  // difference times the q16 gain, exact
  localparam int PROD_BITS   = DIFF_BITS + GAIN_BITS + 1;
  // cordic magnitude growth up to about 2.3x needs two more bits
  localparam int WORK_BITS   = DIFF_BITS + GUARD_SHIFT + 2;
  localparam int TAG_BITS    = 2 * HALF_BITS + 1;
  localparam int ANGLE_SHIFT = TURN_BITS - ANGLE_BITS;
  localparam int REST_LIM    = 2 ** (ANGLE_BITS - 3);

  // ---------------------------------------------------------------
  // stage 1: offsets from the center and angle reduction
  // ---------------------------------------------------------------
  logic                         s1_adv;
  logic                         s1_valid_q;
  logic signed [DIFF_BITS-1:0]  s1_dx_q, s1_dy_q, s1_dz_q;
  logic        [1:0]            s1_quad_q;
  logic signed [ANGLE_BITS-1:0] s1_rest_q;
  logic        [HALF_BITS-1:0]  s1_hx_q, s1_hy_q, s1_hz_q;

  logic signed [DIFF_BITS-1:0]  dx_d, dy_d, dz_d;
  logic        [ANGLE_BITS-1:0] theta, theta_shift, rest_d;
  logic        [1:0]            quad_d;

  assign dx_d = DIFF_BITS'(point_x_i) - DIFF_BITS'(center_x_i);
  assign dy_d = DIFF_BITS'(point_y_i) - DIFF_BITS'(center_y_i);
  assign dz_d = DIFF_BITS'(point_z_i) - DIFF_BITS'(center_z_i);

  // rotate by minus the heading; the quadrant is picked so the rest stays within an eighth turn
  assign theta       = '0 - heading_i;
  assign theta_shift = theta + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
  assign quad_d      = theta_shift[ANGLE_BITS-1 -: 2];
  assign rest_d      = theta - {quad_d, {(ANGLE_BITS-2){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_dx_q   <= dx_d;
      s1_dy_q   <= dy_d;
      s1_dz_q   <= dz_d;
      s1_quad_q <= quad_d;
      s1_rest_q <= $signed(rest_d);
      s1_hx_q   <= half_x_i;
      s1_hy_q   <= half_y_i;
      s1_hz_q   <= half_z_i;
    end
  end

  // ---------------------------------------------------------------
  // stage 2: exact quadrant turn, gain pre-scale, z test
  // ---------------------------------------------------------------
  logic                         s2_adv;
  logic                         s2_valid_q;
  logic signed [WORK_BITS-1:0]  s2_x_q, s2_y_q;
  logic signed [ZACC_BITS-1:0]  s2_z_q;
  logic        [TAG_BITS-1:0]   s2_tag_q;

  logic signed [DIFF_BITS-1:0]  rot_x, rot_y;
  logic signed [PROD_BITS-1:0]  mul_x, mul_y;
  logic signed [ZACC_BITS-1:0]  z_start;
  logic        [DIFF_BITS-1:0]  dz_mag;
  logic                         z_ok;

  // counter-clockwise quarter turns; negation cannot overflow since offsets are symmetric
  always_comb begin
    case (s1_quad_q)
      2'd0:    begin rot_x = s1_dx_q;  rot_y = s1_dy_q;  end
      2'd1:    begin rot_x = -s1_dy_q; rot_y = s1_dx_q;  end
      2'd2:    begin rot_x = -s1_dx_q; rot_y = -s1_dy_q; end
      2'd3:    begin rot_x = s1_dy_q;  rot_y = -s1_dx_q; end
      default: begin rot_x = s1_dx_q;  rot_y = s1_dy_q;  end
    endcase
  end

  assign mul_x = rot_x * INV_GAIN;
  assign mul_y = rot_y * INV_GAIN;

  assign z_start = {{(ZACC_BITS-ANGLE_BITS){s1_rest_q[ANGLE_BITS-1]}}, s1_rest_q} <<< ANGLE_SHIFT;

  assign dz_mag = s1_dz_q[DIFF_BITS-1] ? DIFF_BITS'(-s1_dz_q) : DIFF_BITS'(s1_dz_q);
  assign z_ok   = dz_mag <= DIFF_BITS'(s1_hz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      s2_x_q   <= WORK_BITS'(mul_x);
      s2_y_q   <= WORK_BITS'(mul_y);
      s2_z_q   <= z_start;
      s2_tag_q <= {s1_hx_q, s1_hy_q, z_ok};
    end
  end

  // ---------------------------------------------------------------
  // cordic chain
  // ---------------------------------------------------------------
  logic                        cr_in_stall;
  logic                        cr_out_valid;
  logic                        cr_out_stall;
  logic signed [WORK_BITS-1:0] cr_x, cr_y;
  logic        [TAG_BITS-1:0]  cr_tag;

  obc_cordic #(
    .WORK_BITS (WORK_BITS),
    .STEPS     (CORDIC_STEPS),
    .TAG_BITS  (TAG_BITS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid_q),
    .in_stall_o  (cr_in_stall),
    .x_i         (s2_x_q),
    .y_i         (s2_y_q),
    .z_i         (s2_z_q),
    .tag_i       (s2_tag_q),
    .out_valid_o (cr_out_valid),
    .out_stall_i (cr_out_stall),
    .x_o         (cr_x),
    .y_o         (cr_y),
    .tag_o       (cr_tag)
  );

  // ---------------------------------------------------------------
  // output stage: box test on the rotated offsets
  // ---------------------------------------------------------------
  logic                        out_adv;
  logic                        out_valid_q;
  logic                        inside_q;
  logic        [WORK_BITS-1:0] x_mag, y_mag, x_lim, y_lim;
  logic        [HALF_BITS-1:0] hx_fin, hy_fin;
  logic                        z_ok_fin;

  assign {hx_fin, hy_fin, z_ok_fin} = cr_tag;

  assign x_mag = cr_x[WORK_BITS-1] ? WORK_BITS'(-cr_x) : WORK_BITS'(cr_x);
  assign y_mag = cr_y[WORK_BITS-1] ? WORK_BITS'(-cr_y) : WORK_BITS'(cr_y);
  // half extents moved to the working scale; boundary counts as inside
  assign x_lim = WORK_BITS'({hx_fin, {GUARD_SHIFT{1'b0}}});
  assign y_lim = WORK_BITS'({hy_fin, {GUARD_SHIFT{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= cr_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && cr_out_valid) begin
      inside_q <= (x_mag <= x_lim) && (y_mag <= y_lim) && z_ok_fin;
    end
  end

  // ---------------------------------------------------------------
  // stall chain: each stage moves when empty or when the next one moves
  // ---------------------------------------------------------------
  assign out_adv      = !out_valid_q || !out_stall_i;
  assign cr_out_stall = !out_adv;
  assign s2_adv       = !s2_valid_q || !cr_in_stall;
  assign s1_adv       = !s1_valid_q || s2_adv;

  assign in_stall_o   = !s1_adv;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // input stalls only when the whole pipe is full and the consumer holds off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipe has room");

  // an open input stage captures exactly what is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (s1_valid_q == $past(in_valid_i)))
    else $error("first stage lost or invented a transaction");

  // angle reduction leaves at most an eighth turn for the cordic
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_rest_q >= -REST_LIM && s1_rest_q < REST_LIM))
    else $error("reduced angle outside one eighth turn");

endmodule

// ===== dv/tb_top.sv =====
// testbench for the oriented box containment unit: directed table, random queries, scoreboard
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_W = 24;
  localparam int HALF_W  = COORD_W - 1;
  localparam int ANGLE_W = 16;
  localparam int STEPS   = 16;
  localparam int LATENCY = STEPS + 3;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int TIMEOUT_CYCLES = 400000;

  // 1/K in q16 and atan(2^-k) in units of 2^-32 turn
  localparam longint GAIN_Q16 = 39797;
  localparam longint ATAN_TURN32 [0:STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;
  localparam int MAXH = 8388607;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic        [ANGLE_W-1:0] head;
    logic        [HALF_W-1:0]  hx;
    logic        [HALF_W-1:0]  hy;
    logic        [HALF_W-1:0]  hz;
  } box_query_t;

  // directed row: known marks a result that is typed in rather than predicted
  typedef struct packed {
    box_query_t q;
    bit         known;
    bit         res;
  } query_row_t;

  logic                      clk;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  logic signed [COORD_W-1:0] center_x, center_y, center_z;
  logic        [ANGLE_W-1:0] heading;
  logic        [HALF_W-1:0]  half_x, half_y, half_z;
  logic                      out_valid;
  logic                      out_stall;
  logic                      inside_res;

  query_row_t directed_rows[$];
  bit         expected_inside_q[$];
  bit         burst_mode;
  int         fail_count;
  int         sent_count;
  int         result_count;
  int         inside_count;

  oriented_box_containment_unit #(
    .COORD_BITS  (COORD_W),
    .ANGLE_BITS  (ANGLE_W),
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .point_z_i   (point_z),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .center_z_i  (center_z),
    .heading_i   (heading),
    .half_x_i    (half_x),
    .half_y_i    (half_y),
    .half_z_i    (half_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .inside_res_o(inside_res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // quadrant turn plus cordic on the gain-scaled offset, then exact box compare
  function automatic bit predict_inside(box_query_t q);
    longint             x, y, dz, t, xs, ys, zacc;
    logic [ANGLE_W-1:0] theta, shifted, rest;
    logic [1:0]         quad;
    x  = (longint'($signed(q.px)) - longint'($signed(q.cx))) * GAIN_Q16;
    y  = (longint'($signed(q.py)) - longint'($signed(q.cy))) * GAIN_Q16;
    dz = longint'($signed(q.pz)) - longint'($signed(q.cz));
    theta   = -q.head;
    shifted = theta + ANGLE_W'(1 << (ANGLE_W - 3));
    quad    = shifted[ANGLE_W-1 -: 2];
    rest    = theta - {quad, {(ANGLE_W-2){1'b0}}};
    zacc    = longint'($signed(rest)) * (longint'(1) << (32 - ANGLE_W));
    for (int k = 0; k < int'(quad); k++) begin
      t = x;
      x = -y;
      y = t;
    end
    for (int k = 0; k < STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (zacc >= 0) begin
        x    = x - ys;
        y    = y + xs;
        zacc = zacc - ATAN_TURN32[k];
      end else begin
        x    = x + ys;
        y    = y - xs;
        zacc = zacc + ATAN_TURN32[k];
      end
    end
    return ((x < 0 ? -x : x) <= (longint'(q.hx) << 16)) &&
           ((y < 0 ? -y : y) <= (longint'(q.hy) << 16)) &&
           ((dz < 0 ? -dz : dz) <= longint'(q.hz));
  endfunction

  function automatic void add_row(int px, int py, int pz, int cx, int cy, int cz,
                                  int head, int hx, int hy, int hz, bit known, bit res);
    query_row_t r;
    r.q.px    = COORD_W'(px);
    r.q.py    = COORD_W'(py);
    r.q.pz    = COORD_W'(pz);
    r.q.cx    = COORD_W'(cx);
    r.q.cy    = COORD_W'(cy);
    r.q.cz    = COORD_W'(cz);
    r.q.head  = ANGLE_W'(head);
    r.q.hx    = HALF_W'(hx);
    r.q.hy    = HALF_W'(hy);
    r.q.hz    = HALF_W'(hz);
    r.known   = known;
    r.res     = res;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // offset spread a little past the half extent on both sides
  function automatic int near_offset(logic [HALF_W-1:0] h);
    int hi;
    hi = int'(h);
    return int'($urandom_range(0, 2 * hi + 4)) - (hi + 2);
  endfunction

  function automatic logic [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_W'(MAXC);
      1:       return COORD_W'(MINC);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] extreme_half();
    case ($urandom_range(0, 2))
      0:       return HALF_W'(MAXH);
      1:       return '0;
      default: return HALF_W'(1);
    endcase
  endfunction

  function automatic box_query_t make_query();
    box_query_t q;
    int         mode;
    int         span;
    mode   = $urandom_range(0, 9);
    q.px   = COORD_W'($urandom());
    q.py   = COORD_W'($urandom());
    q.pz   = COORD_W'($urandom());
    q.cx   = COORD_W'($urandom());
    q.cy   = COORD_W'($urandom());
    q.cz   = COORD_W'($urandom());
    q.head = ANGLE_W'($urandom());
    q.hx   = HALF_W'($urandom());
    q.hy   = HALF_W'($urandom());
    q.hz   = HALF_W'($urandom());
    if (mode <= 6) begin
      // points near a box of random scale, so both outcomes are common
      span = $urandom_range(0, HALF_W);
      q.hx = HALF_W'($urandom_range(0, (1 << span) - 1));
      q.hy = HALF_W'($urandom_range(0, (1 << span) - 1));
      q.hz = HALF_W'($urandom_range(0, (1 << span) - 1));
      q.px = COORD_W'(int'(q.cx) + near_offset(q.hx));
      q.py = COORD_W'(int'(q.cy) + near_offset(q.hy));
      q.pz = COORD_W'(int'(q.cz) + near_offset(q.hz));
      if ($urandom_range(0, 3) == 0) begin
        // z offset exactly on a face
        q.pz = $urandom_range(0, 1) ? COORD_W'(int'(q.cz) + int'(q.hz))
                                    : COORD_W'(int'(q.cz) - int'(q.hz));
      end
    end else if (mode == 7) begin
      q.px = extreme_coord();
      q.py = extreme_coord();
      q.pz = extreme_coord();
      q.cx = extreme_coord();
      q.cy = extreme_coord();
      q.cz = extreme_coord();
      q.hx = extreme_half();
      q.hy = extreme_half();
      q.hz = extreme_half();
      if ($urandom_range(0, 1) == 1) q.head = ANGLE_W'($urandom_range(0, 7) << (ANGLE_W - 3));
    end else if (mode == 8) begin
      // degenerate boxes and points sitting on the center
      if ($urandom_range(0, 1) == 1) q.px = q.cx;
      if ($urandom_range(0, 1) == 1) q.py = q.cy;
      if ($urandom_range(0, 1) == 1) q.pz = q.cz;
      if ($urandom_range(0, 1) == 1) q.hx = '0;
      if ($urandom_range(0, 1) == 1) q.hy = '0;
      if ($urandom_range(0, 1) == 1) q.hz = '0;
    end
    return q;
  endfunction

  // one transaction on the input channel; the result is queued once it is accepted
  task automatic send_query(input box_query_t q, input bit res_want, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_x  <= q.px;
    point_y  <= q.py;
    point_z  <= q.pz;
    center_x <= q.cx;
    center_y <= q.cy;
    center_z <= q.cz;
    heading  <= q.head;
    half_x   <= q.hx;
    half_y   <= q.hy;
    half_z   <= q.hz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_inside_q.insert(expected_inside_q.size(), res_want);
    sent_count++;
  endtask

  // hold the sender off until the pipeline has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_inside_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall before each transaction, then compare against the queue
  initial begin
    int wait_cycles;
    bit want;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      wait_cycles = burst_mode ? 0 : $urandom_range(0, 14);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      result_count++;
      if (inside_res === 1'b1) inside_count++;
      if (expected_inside_q.size() == 0) begin
        $error("inside_res arrived with nothing outstanding, actual %0b", inside_res);
        fail_count++;
      end else begin
        want = expected_inside_q.pop_front();
        if (inside_res !== want) begin
          $error("inside_res mismatch: expected %0b, actual %0b", want, inside_res);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("watchdog expired, %0d results outstanding", expected_inside_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    box_query_t q;
    query_row_t r;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    out_stall  = 1'b0;
    point_x    = '0;
    point_y    = '0;
    point_z    = '0;
    center_x   = '0;
    center_y   = '0;
    center_z   = '0;
    heading    = '0;
    half_x     = '0;
    half_y     = '0;
    half_z     = '0;
    burst_mode = 1'b0;

    // point on the center is inside even for a degenerate box
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
    add_row(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 12345, 0, 0, 0, 1, 1);
    add_row(MINC, MINC, MINC, MINC, MINC, MINC, 65535, MAXH, MAXH, MAXH, 1, 1);
    // z spans wider than any half extent
    add_row(0, 0, MAXC, 0, 0, MINC, 0, MAXH, MAXH, MAXH, 1, 0);
    add_row(0, 0, MINC, 0, 0, MAXC, 0, MAXH, MAXH, MAXH, 1, 0);
    // flat box, z one lsb off the plane
    add_row(5, 5, 1, 5, 5, 0, 16384, MAXH, MAXH, 0, 1, 0);
    // z exactly on the top and bottom faces
    add_row(0, 0, MAXC, 0, 0, 0, 32768, 0, 0, MAXH, 1, 1);
    add_row(0, 0, -MAXC, 0, 0, 0, 49152, 0, 0, MAXH, 1, 1);
    // widest xy offsets
    add_row(MAXC, 0, 0, MINC, 0, 0, 0, MAXH, MAXH, MAXH, 0, 0);
    add_row(0, MINC, 0, 0, MAXC, 0, 16384, MAXH, MAXH, MAXH, 0, 0);
    // heading sweep over quadrant and octant edges, offset on the boundary
    add_row(256, 0, 0, 0, 0, 0, 0, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 8191, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 8192, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 8193, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 16384, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 24575, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 24576, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 32768, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 40960, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 49152, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 57343, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 57344, 256, 256, 0, 0, 0);
    add_row(256, 0, 0, 0, 0, 0, 65535, 256, 256, 0, 0, 0);
    // line-shaped box turned a quarter
    add_row(0, 256, 0, 0, 0, 0, 16384, 256, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_query(r.q, r.known ? r.res : predict_inside(r.q), 1'b0);
    end
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every fifth window of 128 transactions runs with no idling on either side
      burst_mode = ((i / 128) % 5) == 4;
      if (i == RANDOM_ITEMS / 2) drain_results();
      q = make_query();
      send_query(q, predict_inside(q), burst_mode);
    end
    burst_mode = 1'b0;
    drain_results();
    repeat (LATENCY + 16) @(posedge clk);

    $display("sent %0d queries (%0d directed), checked %0d results, %0d inside",
             sent_count, directed_rows.size(), result_count, inside_count);
    $display("random part mixed near-box points, extremes, degenerate boxes and full-range noise");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/obc_pkg.sv
rtl/obc_cordic.sv
rtl/oriented_box_containment_unit.sv
dv/tb_top.sv
